// File: sv/wgas_pkg.sv
package wgas_pkg;

   localparam int unsigned TICKS_PER_TENTH_DEF = 781;

   localparam int unsigned TENTHS_W = 7;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned LOAD_W   = 24;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TENTHS_W-1:0] PRE_FLOW_RST  = 7'd5;
   localparam logic [TENTHS_W-1:0] POST_FLOW_RST = 7'd60;
   localparam logic [CNT_W-1:0]    CNT_MAX       = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_PRE_FLOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_FLOW = 2'd1;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRESTART  = 3'd1,
      PH_PREWAIT   = 3'd2,
      PH_HF        = 3'd3,
      PH_WELD      = 3'd4,
      PH_POSTSTART = 3'd5,
      PH_POSTWAIT  = 3'd6
   } phase_type;

   typedef struct packed {
      logic red;
      logic yellow;
      logic arc;
      logic gas;
      logic hf;
   } drive_type;

   typedef struct packed {
      logic                load;
      logic [TENTHS_W-1:0] tenths;
   } tmr_ctl_type;

endpackage

// File: sv/wgas_timer.sv
module wgas_timer #(
   parameter int unsigned TICKS_PER_TENTH = wgas_pkg::TICKS_PER_TENTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  tick,
   input  wgas_pkg::tmr_ctl_type ctl,
   output logic                  ended
);

   logic [wgas_pkg::CNT_W-1:0]  count_ff, count_in, count_dec;
   logic                        running_ff, running_in;
   logic                        done_ff, done_in;
   logic [wgas_pkg::LOAD_W-1:0] load_wide;
   logic [wgas_pkg::CNT_W-1:0]  load_val;
   logic                        done_tick;

   // 1 + n/4 + ticks_per_tenth * n, clamped to the counter range
   always_comb begin
      load_wide = wgas_pkg::LOAD_W'(1)
                + wgas_pkg::LOAD_W'(ctl.tenths >> 2)
                + wgas_pkg::LOAD_W'(TICKS_PER_TENTH) * wgas_pkg::LOAD_W'(ctl.tenths);
      if (load_wide > wgas_pkg::LOAD_W'(wgas_pkg::CNT_MAX)) begin
         load_val = wgas_pkg::CNT_MAX;
      end else begin
         load_val = load_wide[wgas_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      count_dec  = count_ff - wgas_pkg::CNT_W'(1);
      count_in   = count_ff;
      running_in = running_ff;
      done_tick  = done_ff;
      if (running_ff && tick) begin
         count_in = count_dec;
         if (count_dec == '0) begin
            done_tick  = 1'b1;
            running_in = 1'b0;
         end
      end
      ended   = done_tick;
      done_in = done_tick;
      if (done_tick) begin
         done_in    = 1'b0;
         running_in = 1'b0;
      end
      // a load keeps the done flag as it is
      if (ctl.load) begin
         count_in   = load_val;
         running_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (step) begin
         count_ff   <= count_in;
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

endmodule

// File: sv/wgas_fsm.sv
module wgas_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              pedal,
   input  logic                              ended,
   input  logic [wgas_pkg::TENTHS_W-1:0]     pre_tenths,
   input  logic [wgas_pkg::TENTHS_W-1:0]     post_tenths,
   output wgas_pkg::drive_type               drive,
   output logic [2:0]                        phase_now,
   output wgas_pkg::tmr_ctl_type             tmr_ctl
);

   wgas_pkg::phase_type phase_ff, phase_in;

   always_comb begin
      drive          = '0;
      tmr_ctl.load   = 1'b0;
      tmr_ctl.tenths = pre_tenths;
      phase_in       = phase_ff;
      unique case (phase_ff)
         wgas_pkg::PH_IDLE: begin
            if (pedal) phase_in = wgas_pkg::PH_PRESTART;
         end
         wgas_pkg::PH_PRESTART: begin
            drive.yellow = 1'b1;
            drive.gas    = 1'b1;
            tmr_ctl.load = 1'b1;
            phase_in     = wgas_pkg::PH_PREWAIT;
         end
         wgas_pkg::PH_PREWAIT: begin
            drive.yellow = 1'b1;
            drive.gas    = 1'b1;
            if (ended) phase_in = wgas_pkg::PH_HF;
         end
         wgas_pkg::PH_HF: begin
            drive = '{red: 1'b1, yellow: 1'b1, arc: 1'b1, gas: 1'b1, hf: 1'b1};
            if (!pedal) phase_in = wgas_pkg::PH_WELD;
         end
         wgas_pkg::PH_WELD: begin
            drive = '{red: 1'b1, yellow: 1'b1, arc: 1'b1, gas: 1'b1, hf: 1'b0};
            if (pedal) phase_in = wgas_pkg::PH_POSTSTART;
         end
         wgas_pkg::PH_POSTSTART: begin
            drive.yellow   = 1'b1;
            drive.gas      = 1'b1;
            tmr_ctl.load   = 1'b1;
            tmr_ctl.tenths = post_tenths;
            phase_in       = wgas_pkg::PH_POSTWAIT;
         end
         wgas_pkg::PH_POSTWAIT: begin
            drive.yellow = 1'b1;
            drive.gas    = 1'b1;
            if (ended) phase_in = wgas_pkg::PH_IDLE;
         end
         default: begin
            // unused code falls back to idle
            phase_in = wgas_pkg::PH_IDLE;
         end
      endcase
      if (!step) tmr_ctl.load = 1'b0;
   end

   assign phase_now = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wgas_pkg::PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

endmodule

// File: sv/weld_gas_arc_sequencer_core.sv
// channel   valid      stall      payload
// req       req_valid  req_stall  req_pedal_down, req_tick
// rsp       rsp_valid  rsp_stall  rsp_red_led .. rsp_hf_on, rsp_phase
// csr       csr_write  -          csr_index, csr_data
//
// a req transaction reaches rsp_valid through the input register, then the phase
// logic and timer update into the result register; one transaction per cycle unless stalled.
// reset is synchronous and returns phase to idle, timer stopped, flow times 5/60.
// a stalled result holds the result register and the input register; req_stall
// rises only when both are full and rsp_stall is high.
module weld_gas_arc_sequencer_core #(
   parameter int unsigned TICKS_PER_TENTH = wgas_pkg::TICKS_PER_TENTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_pedal_down,
   input  logic                             req_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_red_led,
   output logic                             rsp_yellow_led,
   output logic                             rsp_arc_on,
   output logic                             rsp_gas_valve,
   output logic                             rsp_hf_on,
   output logic [2:0]                       rsp_phase,
   input  logic                             csr_write,
   input  logic [wgas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wgas_pkg::TENTHS_W-1:0]    csr_data
);

   logic [wgas_pkg::TENTHS_W-1:0] pre_ff, post_ff;
   logic                          s0_valid_ff, s0_valid_in;
   logic                          s0_pedal_ff, s0_tick_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   wgas_pkg::drive_type           drive_ff, drive;
   logic [2:0]                    phase_ff, phase_now;
   wgas_pkg::tmr_ctl_type         tmr_ctl;
   logic                          ended;
   logic                          advance, req_take, step;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s0_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign step        = s0_valid_ff && advance;
   assign s0_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s0_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff  <= wgas_pkg::PRE_FLOW_RST;
         post_ff <= wgas_pkg::POST_FLOW_RST;
      end else if (csr_write) begin
         if (csr_index == wgas_pkg::CSR_PRE_FLOW)  pre_ff  <= csr_data;
         if (csr_index == wgas_pkg::CSR_POST_FLOW) post_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_pedal_ff <= req_pedal_down;
         s0_tick_ff  <= req_tick;
      end
      if (step) begin
         drive_ff <= drive;
         phase_ff <= phase_now;
      end
   end

   wgas_timer #(
      .TICKS_PER_TENTH(TICKS_PER_TENTH)
   ) u_timer (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .tick  (s0_tick_ff),
      .ctl   (tmr_ctl),
      .ended (ended)
   );

   wgas_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pedal       (s0_pedal_ff),
      .ended       (ended),
      .pre_tenths  (pre_ff),
      .post_tenths (post_ff),
      .drive       (drive),
      .phase_now   (phase_now),
      .tmr_ctl     (tmr_ctl)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_led    = drive_ff.red;
   assign rsp_yellow_led = drive_ff.yellow;
   assign rsp_arc_on     = drive_ff.arc;
   assign rsp_gas_valve  = drive_ff.gas;
   assign rsp_hf_on      = drive_ff.hf;
   assign rsp_phase      = phase_ff;

   // a held result is never overwritten by the phase logic
   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !step)
      else $error("result register overwritten while stalled");

   // hf relay only in the hf phase
   a_hf_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hf_on) |-> (rsp_phase == wgas_pkg::PH_HF))
      else $error("hf relay outside hf phase");

   // a prestart transaction is always followed by a prewait one
   a_pre_seq: assert property (@(posedge clock) disable iff (reset)
      (step && phase_now == wgas_pkg::PH_PRESTART) |=>
         (phase_now == wgas_pkg::PH_PREWAIT))
      else $error("prestart did not advance to prewait");

endmodule

// File: test/tb_top.sv
module tb_top;

   localparam int HALF_PERIOD  = 10;
   localparam int CLK_PERIOD   = 2 * HALF_PERIOD;
   localparam int RESET_CYCLES = 10;
   localparam int LATENCY      = 2;
   localparam int HOLD_CYCLES  = 80;
   localparam int TICK_PCT     = 90;
   localparam int LIMIT_CYCLES = 1_000_000;

   // indexes past the register file, writes there must be ignored
   localparam logic [wgas_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [wgas_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      wgas_pkg::drive_type drive;
      logic [2:0]          phase;
   } seq_outputs_type;

   class weld_scoreboard;
      localparam int REPORT_CAP = 40;

      logic [2:0]                    seq_phase;
      logic [wgas_pkg::CNT_W-1:0]    tmr_count;
      bit                            tmr_run;
      bit                            tmr_done;
      logic [wgas_pkg::TENTHS_W-1:0] pre_tenths;
      logic [wgas_pkg::TENTHS_W-1:0] post_tenths;
      seq_outputs_type               outputs_due[$];
      int                            errors;
      int                            checked;
      int                            laps;

      function new();
         pre_tenths  = wgas_pkg::PRE_FLOW_RST;
         post_tenths = wgas_pkg::POST_FLOW_RST;
         seq_phase   = wgas_pkg::PH_IDLE;
         tmr_count   = '0;
         tmr_run     = 1'b0;
         tmr_done    = 1'b0;
         errors      = 0;
         checked     = 0;
         laps        = 0;
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      function void write_reg(logic [wgas_pkg::CSR_IDX_W-1:0] idx,
                              logic [wgas_pkg::TENTHS_W-1:0] data);
         if (idx == wgas_pkg::CSR_PRE_FLOW) begin
            pre_tenths = data;
         end else if (idx == wgas_pkg::CSR_POST_FLOW) begin
            post_tenths = data;
         end
      endfunction

      function logic [wgas_pkg::CNT_W-1:0] flow_ticks(logic [wgas_pkg::TENTHS_W-1:0] n);
         int unsigned t;
         t = 32'd1 + 32'(n >> 2) + wgas_pkg::TICKS_PER_TENTH_DEF * 32'(n);
         if (t > 32'(wgas_pkg::CNT_MAX)) t = 32'(wgas_pkg::CNT_MAX);
         return t[wgas_pkg::CNT_W-1:0];
      endfunction

      // one control-loop pass: timer first, then outputs of the current phase
      function void note_pass(logic pedal, logic tick);
         seq_outputs_type due;
         logic            ended;
         logic [2:0]      nxt;
         if (tmr_run && tick) begin
            tmr_count = tmr_count - 1'b1;
            if (tmr_count == '0) begin
               tmr_done = 1'b1;
               tmr_run  = 1'b0;
            end
         end
         ended = tmr_done;
         if (ended) begin
            tmr_done = 1'b0;
            tmr_run  = 1'b0;
         end
         due       = '0;
         due.phase = seq_phase;
         nxt       = seq_phase;
         unique case (seq_phase)
            wgas_pkg::PH_IDLE: begin
               if (pedal) nxt = wgas_pkg::PH_PRESTART;
            end
            wgas_pkg::PH_PRESTART: begin
               due.drive.yellow = 1'b1;
               due.drive.gas    = 1'b1;
               tmr_count = flow_ticks(pre_tenths);
               tmr_run   = 1'b1;
               nxt = wgas_pkg::PH_PREWAIT;
            end
            wgas_pkg::PH_PREWAIT: begin
               due.drive.yellow = 1'b1;
               due.drive.gas    = 1'b1;
               if (ended) nxt = wgas_pkg::PH_HF;
            end
            wgas_pkg::PH_HF: begin
               due.drive = '1;
               if (!pedal) nxt = wgas_pkg::PH_WELD;
            end
            wgas_pkg::PH_WELD: begin
               due.drive    = '1;
               due.drive.hf = 1'b0;
               if (pedal) nxt = wgas_pkg::PH_POSTSTART;
            end
            wgas_pkg::PH_POSTSTART: begin
               due.drive.yellow = 1'b1;
               due.drive.gas    = 1'b1;
               tmr_count = flow_ticks(post_tenths);
               tmr_run   = 1'b1;
               nxt = wgas_pkg::PH_POSTWAIT;
            end
            wgas_pkg::PH_POSTWAIT: begin
               due.drive.yellow = 1'b1;
               due.drive.gas    = 1'b1;
               if (ended) begin
                  nxt  = wgas_pkg::PH_IDLE;
                  laps = laps + 1;
               end
            end
            default: begin
               nxt = wgas_pkg::PH_IDLE;
            end
         endcase
         seq_phase = nxt;
         outputs_due.push_back(due);
      endfunction

      task report(string msg);
         if (errors < REPORT_CAP) $display("ERROR: %s", msg);
         errors = errors + 1;
      endtask

      task check_pass(seq_outputs_type got);
         seq_outputs_type due;
         logic [2:0]      got_f [6];
         logic [2:0]      due_f [6];
         string           names [6];
         if (outputs_due.size() == 0) begin
            report($sformatf("result transaction with nothing due, phase %0d", got.phase));
            return;
         end
         due = outputs_due.pop_front();
         names = '{"red_led", "yellow_led", "arc_on", "gas_valve", "hf_on", "phase"};
         got_f = '{3'(got.drive.red), 3'(got.drive.yellow), 3'(got.drive.arc),
                   3'(got.drive.gas), 3'(got.drive.hf), got.phase};
         due_f = '{3'(due.drive.red), 3'(due.drive.yellow), 3'(due.drive.arc),
                   3'(due.drive.gas), 3'(due.drive.hf), due.phase};
         for (int i = 0; i < 6; i++) begin
            if (got_f[i] !== due_f[i]) begin
               report($sformatf("pass %0d: %s got %0d expected %0d",
                                checked, names[i], got_f[i], due_f[i]));
            end
         end
         checked = checked + 1;
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_pedal_down = 1'b0;
   logic                           req_tick = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_red_led;
   logic                           rsp_yellow_led;
   logic                           rsp_arc_on;
   logic                           rsp_gas_valve;
   logic                           rsp_hf_on;
   logic [2:0]                     rsp_phase;
   logic                           csr_write = 1'b0;
   logic [wgas_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wgas_pkg::TENTHS_W-1:0]  csr_data = '0;

   weld_scoreboard  sb = new();
   seq_outputs_type rsp_seen;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   logic            hold_active = 1'b0;
   event            hold_go;

   weld_gas_arc_sequencer_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pedal_down (req_pedal_down),
      .req_tick       (req_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_led    (rsp_red_led),
      .rsp_yellow_led (rsp_yellow_led),
      .rsp_arc_on     (rsp_arc_on),
      .rsp_gas_valve  (rsp_gas_valve),
      .rsp_hf_on      (rsp_hf_on),
      .rsp_phase      (rsp_phase),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // receiver back-pressure, long hold overrides the random stall
   always @(negedge clock) begin
      rsp_stall <= hold_active || ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         rsp_seen.drive.red    = rsp_red_led;
         rsp_seen.drive.yellow = rsp_yellow_led;
         rsp_seen.drive.arc    = rsp_arc_on;
         rsp_seen.drive.gas    = rsp_gas_valve;
         rsp_seen.drive.hf     = rsp_hf_on;
         rsp_seen.phase        = rsp_phase;
         sb.check_pass(rsp_seen);
      end
   end

   // mostly push the sequencer forward, sometimes hold it back
   function automatic logic pick_pedal(logic [2:0] ph);
      int r;
      r = $urandom_range(99);
      unique case (ph)
         wgas_pkg::PH_IDLE: return r < 70;
         wgas_pkg::PH_HF:   return r >= 70;
         wgas_pkg::PH_WELD: return r < 60;
         default:           return r[0];
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_pass(input logic pedal, input logic tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_pedal_down <= 1'($urandom_range(1));
         req_tick       <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pedal_down <= pedal;
      req_tick       <= tick;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_pass(pedal, tick);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (LATENCY + 1) @(negedge clock);
   endtask

   task automatic csr_poke(input logic [wgas_pkg::CSR_IDX_W-1:0] idx,
                           input logic [wgas_pkg::TENTHS_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic set_flow(input logic [wgas_pkg::TENTHS_W-1:0] pre,
                           input logic [wgas_pkg::TENTHS_W-1:0] post);
      csr_poke(wgas_pkg::CSR_PRE_FLOW, pre);
      csr_poke(wgas_pkg::CSR_POST_FLOW, post);
   endtask

   task automatic run_random(input int n_items, input int send_pct, input int stall_pct,
                             input int hold_at, input int pause_at);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i == hold_at) -> hold_go;
         if (i == pause_at) settle();
         send_pass(pick_pedal(sb.seq_phase), $urandom_range(99) < TICK_PCT);
      end
   endtask

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("timeout: %0d results still due", sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk with one-tick timers
      set_flow('0, '0);
      send_pass(1'b0, 1'b0);
      send_pass(1'b0, 1'b1);   // tick with the timer stopped
      send_pass(1'b1, 1'b0);
      send_pass(1'b1, 1'b1);   // prestart loads the timer
      send_pass(1'b0, 1'b0);   // wait without a tick
      send_pass(1'b1, 1'b1);   // timer expires and is consumed in the same pass
      send_pass(1'b1, 1'b0);
      send_pass(1'b0, 1'b1);
      send_pass(1'b0, 1'b0);
      send_pass(1'b1, 1'b0);
      send_pass(1'b0, 1'b1);
      send_pass(1'b1, 1'b1);
      send_pass(1'b0, 1'b0);
      send_pass(1'b1, 1'b1);
      send_pass(1'b1, 1'b1);
      send_pass(1'b0, 1'b1);
      send_pass(1'b0, 1'b1);
      send_pass(1'b0, 1'b1);
      send_pass(1'b1, 1'b1);
      send_pass(1'b1, 1'b1);
      send_pass(1'b0, 1'b1);
      send_pass(1'b1, 1'b1);
      settle();

      run_random(400, 0, 0, 200, 100);
      settle();
      set_flow(7'd1, '0);
      run_random(300, 61, 0, -1, -1);
      settle();
      set_flow('0, 7'd1);
      run_random(300, 0, 61, -1, -1);
      settle();
      csr_poke(CSR_SPARE_A, '1);
      csr_poke(CSR_SPARE_B, 7'($urandom_range(127)));
      set_flow('0, '0);
      run_random(300, 26, 26, -1, -1);

      settle();
      repeat (LATENCY + 8) @(negedge clock);
      $display("checked %0d passes over %0d complete weld cycles", sb.checked, sb.laps);
      $display("short flow times, idle sender, stalling receiver and one long receiver hold");
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: weld_gas_arc_sequencer_core.f
sv/wgas_pkg.sv
sv/wgas_timer.sv
sv/wgas_fsm.sv
sv/weld_gas_arc_sequencer_core.sv
test/tb_top.sv
